// ===== design/shqz_pkg.sv =====
package shqz_pkg;

    // Field and datapath widths
    localparam int SAMPLE_W = 16;
    localparam int ACC_W    = 32;
    localparam int DIVR_W   = 16;
    localparam int INNER_W  = 8;
    localparam int LEVEL_W  = 9;
    localparam int CFG_IDX_W = 3;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INNER   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAP     = 3'd5;

    // Input opcodes
    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Request to the shared serial divider
    typedef struct packed {
        logic              start;
        logic [ACC_W-1:0]  dividend;
        logic [DIVR_W-1:0] divisor;
    } div_req_t;

    // Status from the shared serial divider
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [ACC_W-1:0] quotient;
    } div_stat_t;

    // Band limits seen by the level decision
    typedef struct packed {
        logic [SAMPLE_W-1:0] top;
        logic [SAMPLE_W-1:0] bottom;
        logic [SAMPLE_W-1:0] gap;
        logic [SAMPLE_W-1:0] band;
        logic [LEVEL_W-1:0]  top_level;
    } band_cfg_t;

endpackage

// ===== design/shqz_div.sv =====
module shqz_div (
    input  logic              clk,
    input  logic              rst_n,
    input  shqz_pkg::div_req_t  req,
    output shqz_pkg::div_stat_t stat
);
    import shqz_pkg::*;

    localparam int CNT_W = $clog2(ACC_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(ACC_W - 1);

    logic [ACC_W-1:0]  quot_reg;
    logic [DIVR_W-1:0] rem_reg;
    logic [DIVR_W-1:0] divisor_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIVR_W:0]   rem_shift;
    logic [DIVR_W:0]   rem_diff;
    logic              fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        rem_shift = {rem_reg, quot_reg[ACC_W-1]};
        rem_diff  = rem_shift - {1'b0, divisor_reg};
        fits      = (rem_shift >= {1'b0, divisor_reg});
    end

    // Control: load on start, step while busy, pulse done after the last bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == LAST) && !req.start;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: quotient bits enter from the right as dividend bits leave
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quot_reg    <= req.dividend;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[ACC_W-2:0], fits};
            rem_reg  <= fits ? rem_diff[DIVR_W-1:0] : rem_shift[DIVR_W-1:0];
        end
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.quotient = quot_reg;

endmodule

// ===== design/shqz_level.sv =====
module shqz_level (
    input  logic                              clk,
    input  logic                              mul_en,
    input  logic [shqz_pkg::LEVEL_W-1:0]      level,
    input  logic [shqz_pkg::SAMPLE_W-1:0]     smooth,
    input  shqz_pkg::band_cfg_t               bands,
    output logic [shqz_pkg::LEVEL_W-1:0]      level_next
);
    import shqz_pkg::*;

    localparam int PROD_W = LEVEL_W + SAMPLE_W;
    localparam int CMP_W  = PROD_W + 2;

    logic [PROD_W-1:0] prod_reg;
    logic [LEVEL_W-1:0] level_m1;
    logic [CMP_W-1:0]  lo_edge;
    logic [CMP_W-1:0]  hi_edge;
    logic [CMP_W-1:0]  smooth_w;
    logic [CMP_W-1:0]  smooth_gap;
    logic [CMP_W-1:0]  top_w;
    logic [CMP_W-1:0]  bot_gap;

    // Register the offset of the current band's lower edge
    assign level_m1 = level - 1'b1;

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= level_m1 * bands.band;
        end
    end

    // Band edges and the smoothed value, all zero-extended so nothing wraps
    always_comb
    begin
        smooth_w   = CMP_W'(smooth);
        smooth_gap = CMP_W'(smooth) + CMP_W'(bands.gap);
        top_w      = CMP_W'(bands.top);
        bot_gap    = CMP_W'(bands.bottom) + CMP_W'(bands.gap);
        lo_edge    = CMP_W'(bands.bottom) + CMP_W'(prod_reg);
        hi_edge    = lo_edge + CMP_W'(bands.band) + CMP_W'(bands.gap);
    end

    // Move at most one step; a level at or above the top band acts as top
    always_comb
    begin
        level_next = level;
        if (level >= bands.top_level)
        begin
            if (smooth_gap < top_w)
            begin
                level_next = level - 1'b1;
            end
        end
        else if (level == '0)
        begin
            if (smooth_w > bot_gap)
            begin
                level_next = level + 1'b1;
            end
        end
        else
        begin
            if (smooth_gap < lo_edge)
            begin
                level_next = level - 1'b1;
            end
            else if (smooth_w > hi_edge)
            begin
                level_next = level + 1'b1;
            end
        end
    end

endmodule

// ===== design/smoothed_hysteresis_level_quantizer.sv =====
// Smoothed hysteresis level quantizer. Each sample item updates a running-sum
// accumulator (accum -= accum/N, accum += sample), takes the smoothed value
// accum/N (saturated to 16 bits) and moves the level index at most one step,
// with gap_width of hysteresis beyond each band edge. A restart item loads
// accum = initial_level*N, puts the level on the top band and latches the
// inner band width (top-bottom)/inner_step_count. Every item returns one
// level_index. Both divisions go through one shared restoring divider that
// resolves one quotient bit per cycle. The input is stalled while an item
// is at work; a finished result waits in the output register, so the next
// item may be taken before it is collected.
module smoothed_hysteresis_level_quantizer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [shqz_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [shqz_pkg::SAMPLE_W-1:0]       cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                opcode,
    input  logic [shqz_pkg::SAMPLE_W-1:0]       sample_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [shqz_pkg::LEVEL_W-1:0]        level_index
);
    import shqz_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV1,
        S_DIV2,
        S_MUL,
        S_CMP,
        S_RWAIT,
        S_OUT
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic [SAMPLE_W-1:0] initial_reg;
    logic [SAMPLE_W-1:0] top_reg;
    logic [SAMPLE_W-1:0] bottom_reg;
    logic [SAMPLE_W-1:0] window_reg;
    logic [INNER_W-1:0]  inner_reg;
    logic [SAMPLE_W-1:0] gap_reg;

    // Block state
    logic [ACC_W-1:0]    accum_reg;
    logic [LEVEL_W-1:0]  level_reg;
    logic [SAMPLE_W-1:0] band_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [SAMPLE_W-1:0] smooth_reg;
    logic                out_valid_reg;
    logic [LEVEL_W-1:0]  level_index_reg;

    logic [SAMPLE_W-1:0] n_eff;
    logic [INNER_W-1:0]  inner_eff;
    logic [LEVEL_W-1:0]  top_level;
    logic [ACC_W:0]      accum_sum;
    logic [ACC_W-1:0]    accum_next;
    logic [SAMPLE_W-1:0] smooth_next;
    logic [LEVEL_W-1:0]  level_next;
    logic                accept;
    logic                mul_en;

    div_req_t  div_req;
    div_stat_t div_stat;
    band_cfg_t bands;

    assign n_eff     = (window_reg == '0) ? SAMPLE_W'(1) : window_reg;
    assign inner_eff = (inner_reg == '0) ? INNER_W'(1) : inner_reg;
    assign top_level = LEVEL_W'(inner_eff) + 1'b1;
    assign accept    = in_valid && !in_stall;
    assign mul_en    = (state_reg == S_MUL);

    // Subtract accum/N, add the sample, saturate at 32 bits
    always_comb
    begin
        accum_sum  = {1'b0, accum_reg} - {1'b0, div_stat.quotient}
                     + (ACC_W + 1)'(sample_reg);
        accum_next = accum_sum[ACC_W] ? {ACC_W{1'b1}} : accum_sum[ACC_W-1:0];
        smooth_next = (|div_stat.quotient[ACC_W-1:SAMPLE_W]) ? {SAMPLE_W{1'b1}}
                      : div_stat.quotient[SAMPLE_W-1:0];
    end

    // Drive the shared divider from the sequencer
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = accum_reg;
        div_req.divisor  = n_eff;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    div_req.start = 1'b1;
                    if (opcode == OP_RESTART)
                    begin
                        div_req.dividend = (top_reg >= bottom_reg)
                                           ? ACC_W'(top_reg - bottom_reg) : '0;
                        div_req.divisor  = DIVR_W'(inner_eff);
                    end
                end
            end
            S_DIV1:
            begin
                div_req.start    = div_stat.done;
                div_req.dividend = accum_next;
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    shqz_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat)
    );

    assign bands.top       = top_reg;
    assign bands.bottom    = bottom_reg;
    assign bands.gap       = gap_reg;
    assign bands.band      = band_reg;
    assign bands.top_level = top_level;

    shqz_level u_level (
        .clk        (clk),
        .mul_en     (mul_en),
        .level      (level_reg),
        .smooth     (smooth_reg),
        .bands      (bands),
        .level_next (level_next)
    );

    // Take configuration writes; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_reg <= '0;
            top_reg     <= {SAMPLE_W{1'b1}};
            bottom_reg  <= '0;
            window_reg  <= SAMPLE_W'(8);
            inner_reg   <= INNER_W'(4);
            gap_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INITIAL: initial_reg <= cfg_data;
                REG_TOP:     top_reg     <= cfg_data;
                REG_BOTTOM:  bottom_reg  <= cfg_data;
                REG_WINDOW:  window_reg  <= cfg_data;
                REG_INNER:   inner_reg   <= cfg_data[INNER_W-1:0];
                REG_GAP:     gap_reg     <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Payload captures
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample_value;
        end
        if ((state_reg == S_DIV2) && div_stat.done)
        begin
            smooth_reg <= smooth_next;
        end
    end

    // Sequencer with state and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            accum_reg       <= '0;
            level_reg       <= '0;
            band_reg        <= '0;
            out_valid_reg   <= 1'b0;
            level_index_reg <= '0;
        end
        else
        begin
            // Drop the result once it is taken; a finishing item reloads it instead
            if (out_valid_reg && !out_stall && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (opcode == OP_RESTART)
                        begin
                            accum_reg <= ACC_W'(initial_reg) * ACC_W'(n_eff);
                            level_reg <= top_level;
                            state_reg <= S_RWAIT;
                        end
                        else
                        begin
                            state_reg <= S_DIV1;
                        end
                    end
                end
                S_DIV1:
                begin
                    if (div_stat.done)
                    begin
                        accum_reg <= accum_next;
                        state_reg <= S_DIV2;
                    end
                end
                S_DIV2:
                begin
                    if (div_stat.done)
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    level_reg <= level_next;
                    state_reg <= S_OUT;
                end
                S_RWAIT:
                begin
                    if (div_stat.done)
                    begin
                        band_reg  <= div_stat.quotient[SAMPLE_W-1:0];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    // Hold until the output register is free
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg   <= 1'b1;
                        level_index_reg <= level_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign level_index = level_index_reg;

    // An accepted item closes the input until its work is done
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("input not stalled after an item was accepted");

    // The divider only finishes while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIV1 || state_reg == S_DIV2
                           || state_reg == S_RWAIT))
        else $error("divider finished outside a wait state");

    // The divider is quiet whenever the block is idle
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !div_stat.busy)
        else $error("divider busy while the block is idle");

    // A new result is loaded only from the output state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result appeared without finishing an item");

endmodule
